// ===== hw/rtl/bdq_pkg.sv =====
package bdq_pkg;

    localparam int CAPACITY = 16;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int DATA_W   = 32;

    localparam logic [2:0] CMD_PUSH_BACK  = 3'd0;
    localparam logic [2:0] CMD_PUSH_FRONT = 3'd1;
    localparam logic [2:0] CMD_POP_BACK   = 3'd2;
    localparam logic [2:0] CMD_POP_FRONT  = 3'd3;
    localparam logic [2:0] CMD_ERASE      = 3'd4;
    localparam logic [2:0] CMD_CLEAR      = 3'd5;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_NONE  = 2'd2;
    localparam logic [1:0] ST_FULL  = 2'd3;

    typedef enum logic [2:0] {
        CELL_HOLD,
        CELL_LOAD,
        CELL_SHR,
        CELL_SHL,
        CELL_ERASE
    } t_cell_op;

    typedef struct packed {
        t_cell_op                   op;
        logic signed [DATA_W-1:0]   value;
        logic        [CNT_W-1:0]    count;
    } t_cell_ctl;

endpackage

// ===== hw/rtl/bounded_deque_with_erase.sv =====
// Bounded double-ended queue of signed 32-bit words with erase by value.
// Input channel: i_in_valid / o_in_ready carry i_command and i_item_value.
// Output channel: o_out_valid / i_out_ready carry o_removed_value, o_status
// and o_entry_count; every input word gives exactly one result word.
// Commands: push back, push front, pop back, pop front, erase first match
// from the front (later entries close the gap), clear; other codes do nothing.
// Storage is a row of CAPACITY cells, each shifting to a neighbour per cycle;
// the erase search ripples a match flag down the row in the same cycle.
// The result is registered and appears in the cycle after the input word is accepted.
// One word per cycle while the receiver takes each result; the single output
// register is refilled in the cycle it is taken.
// Reset (synchronous, active low) empties the queue and the output register;
// cell contents are not cleared and are only read once written.
// If the receiver stalls, the result is held and o_in_ready drops until it
// is taken.
module bounded_deque_with_erase
    import bdq_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_in_valid,
    output logic                     o_in_ready,
    input  logic [2:0]               i_command,
    input  logic signed [DATA_W-1:0] i_item_value,
    output logic                     o_out_valid,
    input  logic                     i_out_ready,
    output logic signed [DATA_W-1:0] o_removed_value,
    output logic [1:0]               o_status,
    output logic [4:0]               o_entry_count
);

    logic [CNT_W-1:0]          r_count;
    logic [CNT_W-1:0]          n_count;
    logic                      r_out_valid;
    logic signed [DATA_W-1:0]  r_removed;
    logic [1:0]                r_status;
    logic signed [DATA_W-1:0]  n_removed;
    logic [1:0]                n_status;
    logic                      w_accept;
    logic                      w_full;
    logic                      w_empty;
    t_cell_ctl                 w_ctl;

    logic signed [DATA_W-1:0]  w_data  [CAPACITY];
    logic                      w_match [CAPACITY+1];
    logic signed [DATA_W-1:0]  w_tail  [CAPACITY+1];

    assign o_in_ready = !r_out_valid || i_out_ready;
    assign w_accept   = i_in_valid && o_in_ready;
    assign w_full     = r_count == CNT_W'(CAPACITY);
    assign w_empty    = r_count == '0;

    assign w_match[0] = 1'b0;
    assign w_tail[0]  = '0;

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic signed [DATA_W-1:0] w_left;
        logic signed [DATA_W-1:0] w_right;

        if (g == 0) begin : g_first
            assign w_left = i_item_value;
        end else begin : g_mid_l
            assign w_left = w_data[g-1];
        end
        if (g == CAPACITY - 1) begin : g_last
            assign w_right = w_data[g];
        end else begin : g_mid_r
            assign w_right = w_data[g+1];
        end

        bdq_cell u_cell (
            .i_clk   (i_clk),
            .i_index (IDX_W'(g)),
            .i_ctl   (w_ctl),
            .i_left  (w_left),
            .i_right (w_right),
            .i_match (w_match[g]),
            .i_tail  (w_tail[g]),
            .o_data  (w_data[g]),
            .o_match (w_match[g+1]),
            .o_tail  (w_tail[g+1])
        );
    end

    always_comb begin
        w_ctl.op    = CELL_HOLD;
        w_ctl.value = i_item_value;
        w_ctl.count = r_count;
        n_count     = r_count;
        n_removed   = '0;
        n_status    = ST_OK;
        case (i_command)
            CMD_PUSH_BACK: begin
                if (w_full) begin
                    n_status = ST_FULL;
                end else begin
                    w_ctl.op = CELL_LOAD;
                    n_count  = r_count + CNT_W'(1);
                end
            end
            CMD_PUSH_FRONT: begin
                if (w_full) begin
                    n_status = ST_FULL;
                end else begin
                    w_ctl.op = CELL_SHR;
                    n_count  = r_count + CNT_W'(1);
                end
            end
            CMD_POP_BACK: begin
                if (w_empty) begin
                    n_status = ST_EMPTY;
                end else begin
                    n_removed = w_tail[CAPACITY];
                    n_count   = r_count - CNT_W'(1);
                end
            end
            CMD_POP_FRONT: begin
                if (w_empty) begin
                    n_status = ST_EMPTY;
                end else begin
                    w_ctl.op  = CELL_SHL;
                    n_removed = w_data[0];
                    n_count   = r_count - CNT_W'(1);
                end
            end
            CMD_ERASE: begin
                if (w_match[CAPACITY]) begin
                    w_ctl.op = CELL_ERASE;
                    n_count  = r_count - CNT_W'(1);
                end else begin
                    n_status = ST_NONE;
                end
            end
            CMD_CLEAR: n_count = '0;
            default:   n_count = r_count;
        endcase
        if (!w_accept) begin
            w_ctl.op = CELL_HOLD;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_accept) begin
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
        if (w_accept) begin
            r_removed <= n_removed;
            r_status  <= n_status;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_removed_value = r_removed;
    assign o_status        = r_status;
    assign o_entry_count   = 5'(r_count);

endmodule

// ===== hw/rtl/bdq_cell.sv =====
module bdq_cell
    import bdq_pkg::*;
(
    input  logic                     i_clk,
    input  logic [IDX_W-1:0]         i_index,
    input  t_cell_ctl                i_ctl,
    input  logic signed [DATA_W-1:0] i_left,
    input  logic signed [DATA_W-1:0] i_right,
    input  logic                     i_match,
    input  logic signed [DATA_W-1:0] i_tail,
    output logic signed [DATA_W-1:0] o_data,
    output logic                     o_match,
    output logic signed [DATA_W-1:0] o_tail
);

    logic signed [DATA_W-1:0] r_data;
    logic signed [DATA_W-1:0] n_data;
    logic [CNT_W-1:0]         w_pos;
    logic                     w_occupied;
    logic                     w_hit;

    assign w_pos      = CNT_W'(i_index);
    assign w_occupied = w_pos < i_ctl.count;
    assign w_hit      = w_occupied && (r_data == i_ctl.value);

    // match ripples from the front; everything at or behind the first hit closes up
    assign o_match = i_match | w_hit;
    assign o_tail  = i_tail | (((w_pos + CNT_W'(1)) == i_ctl.count) ? r_data : '0);
    assign o_data  = r_data;

    always_comb begin
        n_data = r_data;
        case (i_ctl.op)
            CELL_LOAD:  if (w_pos == i_ctl.count) n_data = i_ctl.value;
            CELL_SHR:   n_data = i_left;
            CELL_SHL:   n_data = i_right;
            CELL_ERASE: if (o_match) n_data = i_right;
            default:    n_data = r_data;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

endmodule
